// ----- rtl/tdpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_pkg
// shared types for the trial division prime counter
// ----------------------------------------------------------------------------
package tdpc_pkg;

	// status from the serial remainder unit back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} rem_stat_t;

endpackage
`default_nettype wire

// ----- rtl/tdpc_serial_rem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_serial_rem
// bit-serial restoring remainder: dividend shifted in msb first, one bit a cycle
// ----------------------------------------------------------------------------
module tdpc_serial_rem #(
	parameter int VALUE_BITS = 18
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [VALUE_BITS-1:0]                  dividend,
	input  wire logic [(VALUE_BITS+1)/2:0]              divisor,
	output tdpc_pkg::rem_stat_t                         stat
);

	localparam int HW = (VALUE_BITS + 1) / 2 + 1;
	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] shift_q;
	logic [HW-1:0]         rem_q;
	logic [HW-1:0]         div_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [HW:0]           rem_sh;
	logic [HW:0]           rem_sub;
	logic [HW-1:0]         rem_nxt;

	assign rem_sh  = {rem_q, shift_q[VALUE_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign rem_nxt = (rem_sh >= {1'b0, div_q}) ? rem_sub[HW-1:0] : rem_sh[HW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			rem_q   <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule
`default_nettype wire

// ----- rtl/tdpc_result.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_result
// saturating prime tally and output word register
// ----------------------------------------------------------------------------
module tdpc_result #(
	parameter int VALUE_BITS = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic                  prime,
	output logic                       free,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       prime_flag,
	output logic [VALUE_BITS-1:0]      primes_so_far
);

	logic                  valid_q;
	logic                  prime_q;
	logic [VALUE_BITS-1:0] tally_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tally_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				if (prime && (tally_q != '1)) begin
					tally_q <= tally_q + 1'b1;
				end
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prime_q <= prime;
		end
	end

	assign out_valid     = valid_q;
	assign prime_flag    = prime_q;
	assign primes_so_far = tally_q;

endmodule
`default_nettype wire

// ----- rtl/trial_division_prime_counter.sv -----
`default_nettype none
// trial divisors run from 2 up to the square root of the candidate
// one word in flight; the bit-serial remainder unit is run once per trial divisor
// a finished result waits in the output register while the next word is taken
// arst_n clears the prime tally, the sequencer and the output valid
// ----------------------------------------------------------------------------
// trial_division_prime_counter
// trial division primality test with a saturating count of primes seen
// ----------------------------------------------------------------------------
module trial_division_prime_counter #(
	parameter int VALUE_BITS = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VALUE_BITS-1:0] candidate,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       prime_flag,
	output logic [VALUE_BITS-1:0]      primes_so_far
);

	localparam int HW = (VALUE_BITS + 1) / 2 + 1;
	localparam int SW = VALUE_BITS + 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [HW-1:0]         d_q;
	logic [SW-1:0]         sq_q;
	logic                  prime_q;
	logic                  rem_start;
	logic                  res_free;
	logic                  res_load;
	tdpc_pkg::rem_stat_t   rem_stat;

	assign in_stall  = (state_q != ST_IDLE);
	assign rem_start = (state_q == ST_CHECK) && (n_q[VALUE_BITS-1:1] != '0)
		&& (sq_q <= {2'b00, n_q});
	assign res_load  = (state_q == ST_FIN) && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (rem_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (rem_stat.done) begin
						state_q <= rem_stat.zero ? ST_FIN : ST_CHECK;
					end
				end
				ST_FIN: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			n_q  <= candidate;
			d_q  <= HW'(2);
			sq_q <= SW'(4);
		end else if ((state_q == ST_CHECK) && !rem_start) begin
			// below two is not prime; divisor square past n means no factor found
			prime_q <= (n_q[VALUE_BITS-1:1] != '0);
		end else if ((state_q == ST_DIV) && rem_stat.done) begin
			d_q     <= d_q + 1'b1;
			sq_q    <= sq_q + SW'({d_q, 1'b1});
			prime_q <= 1'b0;
		end
	end

	tdpc_serial_rem #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(n_q),
		.divisor (d_q),
		.stat    (rem_stat)
	);

	tdpc_result #(
		.VALUE_BITS(VALUE_BITS)
	) u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_load),
		.prime        (prime_q),
		.free         (res_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.prime_flag   (prime_flag),
		.primes_so_far(primes_so_far)
	);

`ifndef ASSERT_OFF
	a_rem_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_stat.done || rem_stat.busy) |-> (state_q == ST_DIV))
		else $error("remainder unit active outside divide state");

	a_tally_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		primes_so_far >= $past(primes_so_far))
		else $error("prime tally decreased");

	a_composite_keeps_tally: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !prime_q) |=> $stable(primes_so_far))
		else $error("tally changed on a non-prime word");
`endif

endmodule
`default_nettype wire
